// ===== rtl/dsvp_pkg.sv =====
// shared types and constants of the delimiter-separated text field parser
package dsvp_pkg;

    // byte codes with a fixed meaning
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    // configuration register indexes and reset values
    localparam logic CFG_DELIMITER = 1'b0;
    localparam logic CFG_QUOTE     = 1'b1;
    localparam logic [7:0] DELIMITER_RESET = 8'd59;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;

    // command queue depth, a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // one classified input byte: one result, or two content bytes
    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       byte_valid;
        logic       field_end;
        logic       line_end;
        logic       stream_end;
    } cmd_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/dsvp_front.sv =====
// front end: parse state machine that classifies each input byte into a command
module dsvp_front (
    input  logic              clk,
    input  logic              rst_n,
    // configuration writes
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    // input transaction
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              end_marker,
    // command to the queue
    output logic              cmd_push,
    output dsvp_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        PH_LINE_START  = 3'd0,
        PH_FIELD_START = 3'd1,
        PH_REGULAR     = 3'd2,
        PH_QUOTED      = 3'd3,
        PH_ENDED       = 3'd4
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       quote_pending_reg, quote_pending_next;
    logic       after_cr_reg, after_cr_next;
    logic       field_started_reg, field_started_next;
    logic [7:0] delimiter_reg, delimiter_next;
    logic [7:0] quote_reg, quote_next;
    logic       emit;

    logic is_nl, is_quote, is_delim;

    assign is_nl    = (in_byte == dsvp_pkg::CH_CR) || (in_byte == dsvp_pkg::CH_LF);
    assign is_quote = (in_byte == quote_reg);
    assign is_delim = (in_byte == delimiter_reg);

    // configuration registers
    always_comb
    begin
        delimiter_next = delimiter_reg;
        quote_next     = quote_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dsvp_pkg::CFG_DELIMITER: delimiter_next = cfg_data;
                dsvp_pkg::CFG_QUOTE:     quote_next     = cfg_data;
                default:                 delimiter_next = delimiter_reg;
            endcase
        end
    end

    // classification and next parse state
    always_comb
    begin
        phase_next         = phase_reg;
        quote_pending_next = quote_pending_reg;
        after_cr_next      = after_cr_reg;
        field_started_next = field_started_reg;
        emit               = 1'b0;
        cmd                = '0;

        if (phase_reg == PH_ENDED)
        begin
            emit           = 1'b1;
            cmd.stream_end = 1'b1;
        end
        else if (end_marker)
        begin
            emit           = 1'b1;
            cmd.field_end  = field_started_reg;
            cmd.line_end   = field_started_reg;
            cmd.stream_end = 1'b1;
            phase_next         = PH_ENDED;
            quote_pending_next = 1'b0;
            after_cr_next      = 1'b0;
            field_started_next = 1'b0;
        end
        else
        begin
            after_cr_next = 1'b0;
            unique case (phase_reg)
                PH_LINE_START, PH_FIELD_START:
                begin
                    if (phase_reg == PH_LINE_START && after_cr_reg
                        && in_byte == dsvp_pkg::CH_LF)
                    begin
                        // lf of a crlf pair is absorbed
                        emit = 1'b0;
                    end
                    else if (is_quote)
                    begin
                        phase_next         = PH_QUOTED;
                        quote_pending_next = 1'b0;
                        field_started_next = 1'b1;
                    end
                    else if (is_nl)
                    begin
                        emit               = 1'b1;
                        cmd.field_end      = 1'b1;
                        cmd.line_end       = 1'b1;
                        phase_next         = PH_LINE_START;
                        field_started_next = 1'b0;
                        quote_pending_next = 1'b0;
                        after_cr_next      = (in_byte == dsvp_pkg::CH_CR);
                    end
                    else if (is_delim)
                    begin
                        emit               = 1'b1;
                        cmd.field_end      = 1'b1;
                        phase_next         = PH_FIELD_START;
                        field_started_next = 1'b1;
                        quote_pending_next = 1'b0;
                    end
                    else
                    begin
                        emit               = 1'b1;
                        cmd.byte0          = in_byte;
                        cmd.byte_valid     = 1'b1;
                        phase_next         = PH_REGULAR;
                        field_started_next = 1'b1;
                    end
                end
                PH_REGULAR:
                begin
                    emit = 1'b1;
                    if (is_nl)
                    begin
                        cmd.field_end      = 1'b1;
                        cmd.line_end       = 1'b1;
                        phase_next         = PH_LINE_START;
                        field_started_next = 1'b0;
                        quote_pending_next = 1'b0;
                        after_cr_next      = (in_byte == dsvp_pkg::CH_CR);
                    end
                    else if (is_delim)
                    begin
                        cmd.field_end      = 1'b1;
                        phase_next         = PH_FIELD_START;
                        field_started_next = 1'b1;
                        quote_pending_next = 1'b0;
                    end
                    else
                    begin
                        cmd.byte0      = in_byte;
                        cmd.byte_valid = 1'b1;
                    end
                end
                PH_QUOTED:
                begin
                    if (quote_pending_reg)
                    begin
                        emit               = 1'b1;
                        quote_pending_next = 1'b0;
                        if (is_nl)
                        begin
                            cmd.field_end      = 1'b1;
                            cmd.line_end       = 1'b1;
                            phase_next         = PH_LINE_START;
                            field_started_next = 1'b0;
                            after_cr_next      = (in_byte == dsvp_pkg::CH_CR);
                        end
                        else if (is_delim)
                        begin
                            cmd.field_end      = 1'b1;
                            phase_next         = PH_FIELD_START;
                            field_started_next = 1'b1;
                        end
                        else if (is_quote)
                        begin
                            // doubled quote gives one literal quote
                            cmd.byte0      = in_byte;
                            cmd.byte_valid = 1'b1;
                        end
                        else
                        begin
                            // stray quote is kept, then the byte itself
                            cmd.two        = 1'b1;
                            cmd.byte0      = quote_reg;
                            cmd.byte1      = in_byte;
                            cmd.byte_valid = 1'b1;
                        end
                    end
                    else if (is_quote)
                    begin
                        quote_pending_next = 1'b1;
                    end
                    else
                    begin
                        emit           = 1'b1;
                        cmd.byte0      = in_byte;
                        cmd.byte_valid = 1'b1;
                    end
                end
                default:
                begin
                    phase_next     = PH_ENDED;
                    emit           = 1'b1;
                    cmd.stream_end = 1'b1;
                end
            endcase
        end
    end

    assign cmd_push = accept && emit;

    // parse state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LINE_START;
            quote_pending_reg <= 1'b0;
            after_cr_reg      <= 1'b0;
            field_started_reg <= 1'b0;
            delimiter_reg     <= dsvp_pkg::DELIMITER_RESET;
            quote_reg         <= dsvp_pkg::QUOTE_RESET;
        end
        else
        begin
            delimiter_reg <= delimiter_next;
            quote_reg     <= quote_next;
            if (accept)
            begin
                phase_reg         <= phase_next;
                quote_pending_reg <= quote_pending_next;
                after_cr_reg      <= after_cr_next;
                field_started_reg <= field_started_next;
            end
        end
    end

endmodule

// ===== rtl/dsvp_queue.sv =====
// short command queue between the parser front end and the result back end
module dsvp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  dsvp_pkg::cmd_t          push_data,
    input  logic                    pop,
    output dsvp_pkg::cmd_t          head,
    output dsvp_pkg::queue_status_t status
);

    dsvp_pkg::cmd_t                     entry_reg [dsvp_pkg::QUEUE_DEPTH];
    logic [dsvp_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [dsvp_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == dsvp_pkg::QUEUE_CNT_W'(dsvp_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    // occupancy
    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/dsvp_back.sv =====
// back end: expands queued commands into result transactions on the output register
module dsvp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dsvp_pkg::cmd_t          head,
    input  dsvp_pkg::queue_status_t status,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,
    output logic [3:0]              m_tuser,
    output logic                    m_tlast
);

    logic       valid_reg, valid_next;
    logic       second_reg, second_next;
    logic [7:0] data_reg, data_next;
    logic [3:0] user_reg, user_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = !status.empty && (!valid_reg || m_tready);
    assign pop  = load && (!head.two || second_reg);

    // next result from the head command
    always_comb
    begin
        second_next = second_reg;
        data_next   = data_reg;
        user_next   = user_reg;
        last_next   = last_reg;
        valid_next  = valid_reg && !m_tready;
        if (load)
        begin
            valid_next = 1'b1;
            if (head.two && !second_reg)
            begin
                second_next = 1'b1;
                data_next   = head.byte0;
                user_next   = 4'b0001;
                last_next   = 1'b0;
            end
            else if (head.two)
            begin
                second_next = 1'b0;
                data_next   = head.byte1;
                user_next   = 4'b0001;
                last_next   = 1'b1;
            end
            else
            begin
                data_next = head.byte0;
                user_next = {head.stream_end, head.line_end, head.field_end,
                             head.byte_valid};
                last_next = 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/dsv_field_parser_top.sv =====
// top level of the delimiter-separated text field parser
//
// Input stream: one text byte per transaction on s_tdata; s_tlast marks the
// end of the stream and then the byte is ignored. Output stream: one result
// per transaction; m_tdata is the content byte, m_tuser carries byte_valid,
// field_end, line_end and stream_end, m_tlast marks the last result of an
// input byte. A byte gives zero, one or two results.
// The delimiter and quote bytes are set through cfg_we/cfg_index/cfg_data
// (index 0 delimiter, index 1 quote); the user must do so only while the block
// is idle; the block does not enforce it. A result passes through the command
// queue and the output register. Throughput: one input byte per cycle unless the
// queue is full; a byte with two results lets the output set the sustained rate.
// A four-entry command queue between the parser and the output register
// lets the input run on while the receiver stalls; s_tready falls only when
// that queue is full.
// Reset clears the parse state, empties the queue and the output register,
// and restores the delimiter to ';' and the quote to '"'.
module dsv_field_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write port
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // end_marker
    // output stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [3:0] m_tuser,   // byte_valid, field_end, line_end, stream_end
    output logic       m_tlast    // last_result
);

    logic                    accept;
    logic                    q_push;
    logic                    q_pop;
    dsvp_pkg::cmd_t          q_cmd;
    dsvp_pkg::cmd_t          q_head;
    dsvp_pkg::queue_status_t q_status;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    // parser front end
    dsvp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .in_byte    (s_tdata),
        .end_marker (s_tlast),
        .cmd_push   (q_push),
        .cmd        (q_cmd)
    );

    // command queue
    dsvp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_cmd),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    // result back end
    dsvp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .status   (q_status),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // no command is written into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_status.full))
        else $error("command pushed into full queue");

    // the back end never pops an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("command popped from empty queue");

    // a result that is not the last of its byte is always a content byte
    a_first_is_content: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser == 4'b0001))
        else $error("non-final result is not a plain content byte");

    // a two-result command is popped while its first byte is shown, as its second is loaded
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.two) |=> (m_tvalid && m_tlast && $past(m_tvalid)))
        else $error("two-result command popped before its first byte");
`endif

endmodule
